>>> hw/rtl/ddr_pkg.sv
package ddr_pkg;

    localparam int OP_W   = 2;
    localparam int EV_W   = 2;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 5;
    localparam int OUTV_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD_CELL  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_AVAIL = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN        = 2'd2;

    localparam logic [EV_W-1:0] EV_TERMINATED = 2'd0;
    localparam logic [EV_W-1:0] EV_COMPLETED  = 2'd1;
    localparam logic [EV_W-1:0] EV_END        = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_NUM_PROCS     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NUM_RESOURCES = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_INIT,
        ST_SCAN,
        ST_ROW_RD,
        ST_ROW_USE,
        ST_ROW_END,
        ST_VS_SCAN,
        ST_VS_RD,
        ST_VS_USE,
        ST_VS_END,
        ST_TERM_EMIT,
        ST_TERM_RD,
        ST_TERM_USE,
        ST_REPORT
    } state_t;

endpackage

>>> hw/rtl/ddr_ram.sv
module ddr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/deadlock_detect_recover_top.sv
// Deadlock detection and recovery engine.
// Input channel s_*: opcode 0 loads one request/allocation cell of a process,
// opcode 1 loads one available entry, opcode 2 runs detection and recovery,
// opcode 3 is dropped. Loads give no result.
// Result channel m_*: a run gives one terminate item per victim, then one
// completed item per surviving process in completion order, then an end item
// with m_last high carrying the completed count.
// Configuration port cfg_*: index 0 num_procs, index 1 num_resources; write
// only while idle. cfg_ready is always high.
// A run walks the request/allocation memory cell by cell through its single
// read port, a read state then a use state per cell: detection rescans from
// process 0 after each completion, victim selection sums every unfinished row,
// and recovery returns the victim's allocations to the available entries.
// s_ready is high only while idle, so one run occupies the block until its
// end item is registered. A stalled m_ready holds the output register and
// the sequencer waits on it.
// Reset clears control state and the masks; tables are undefined until loaded.
module deadlock_detect_recover_top
    import ddr_pkg::*;
#(
    parameter int MAX_PROCS     = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int UNIT_BITS     = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [3:0]        s_process,
    input  logic [2:0]        s_resource,
    input  logic [7:0]        s_request_units,
    input  logic [7:0]        s_alloc_units,
    input  logic [7:0]        s_avail_units,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_event_kind,
    output logic [4:0]        m_proc_or_count,
    output logic              m_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CDAT_W-1:0] cfg_data
);

    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int AW    = UNIT_BITS + 5;
    localparam int TW    = UNIT_BITS + 1 + $clog2(MAX_RESOURCES + 1);
    localparam int DEPTH = MAX_PROCS * (1 << RW);
    localparam int MAW   = $clog2(DEPTH);

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a,
                                              input logic [UNIT_BITS-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(b);
        return s[AW] ? {AW{1'b1}} : s[AW-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [CDAT_W-1:0]     nprocs_reg, nprocs_next;
    logic [3:0]            nres_reg, nres_next;
    logic [CW-1:0]         np_reg, np_next;
    logic [RCW-1:0]        nr_reg, nr_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [RW-1:0]         j_reg, j_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  fits_reg, fits_next;
    logic                  have_reg, have_next;
    logic [TW-1:0]         tot_reg, tot_next;
    logic [TW-1:0]         best_reg, best_next;
    logic [PW-1:0]         victim_reg, victim_next;
    logic [MAX_PROCS-1:0]  fin_reg, fin_next;
    logic [MAX_PROCS-1:0]  term_reg, term_next;
    logic [AW-1:0]         avail_reg [MAX_RESOURCES];
    logic [AW-1:0]         avail_next [MAX_RESOURCES];
    logic [AW-1:0]         work_reg [MAX_RESOURCES];
    logic [AW-1:0]         work_next [MAX_RESOURCES];
    logic [UNIT_BITS-1:0]  abuf_reg [MAX_RESOURCES];
    logic [UNIT_BITS-1:0]  abuf_next [MAX_RESOURCES];
    logic [PW-1:0]         order_reg [MAX_PROCS];
    logic [PW-1:0]         order_next [MAX_PROCS];
    logic                  mv_reg, mv_next;
    logic [EV_W-1:0]       kind_reg, kind_next;
    logic [OUTV_W-1:0]     val_reg, val_next;
    logic                  last_reg, last_next;

    logic                  ram_we;
    logic [MAW-1:0]        ram_waddr, ram_raddr;
    logic [2*UNIT_BITS-1:0] ram_wdata, ram_rdata;
    logic [UNIT_BITS-1:0]  rd_req, rd_alloc;
    logic                  s_fire, out_free, j_last, i_end, any_unfin;
    logic [MAX_PROCS-1:0]  np_mask;
    logic [PW-1:0]         i_idx;

    ddr_ram #(
        .WIDTH (2*UNIT_BITS),
        .DEPTH (DEPTH)
    ) u_tables (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_req    = ram_rdata[2*UNIT_BITS-1:UNIT_BITS];
    assign rd_alloc  = ram_rdata[UNIT_BITS-1:0];
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !mv_reg || m_ready;
    assign i_idx     = i_reg[PW-1:0];
    assign j_last    = (RCW'(j_reg) + RCW'(1)) == nr_reg;
    assign i_end     = (i_reg == np_reg);

    always_comb begin
        for (int k = 0; k < MAX_PROCS; k++) begin
            np_mask[k] = (k < np_reg);
        end
    end
    assign any_unfin = |(~fin_reg & np_mask);

    assign m_valid         = mv_reg;
    assign m_event_kind    = kind_reg;
    assign m_proc_or_count = val_reg;
    assign m_last          = last_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {PW'(s_process), RW'(s_resource)};
        ram_wdata = {UNIT_BITS'(s_request_units), UNIT_BITS'(s_alloc_units)};
        ram_raddr = {i_idx, j_reg};
        if (state_reg == ST_IDLE) begin
            ram_we = s_fire && (s_opcode == OP_LOAD_CELL)
                     && (32'(s_process) < MAX_PROCS) && (32'(s_resource) < MAX_RESOURCES);
        end else if (state_reg == ST_TERM_USE) begin
            ram_we    = 1'b1;
            ram_waddr = {victim_reg, j_reg};
            ram_wdata = '0;
        end
        if (state_reg == ST_TERM_RD) begin
            ram_raddr = {victim_reg, j_reg};
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_opcode == OP_RUN) state_next = ST_DET_INIT;
            end
            ST_DET_INIT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (i_end) state_next = any_unfin ? ST_VS_SCAN : ST_REPORT;
                else if (!fin_reg[i_idx]) state_next = ST_ROW_RD;
            end
            ST_ROW_RD:  state_next = ST_ROW_USE;
            ST_ROW_USE: state_next = j_last ? ST_ROW_END : ST_ROW_RD;
            ST_ROW_END: state_next = ST_SCAN;
            ST_VS_SCAN: begin
                if (i_end) state_next = ST_TERM_EMIT;
                else if (!fin_reg[i_idx]) state_next = ST_VS_RD;
            end
            ST_VS_RD:   state_next = ST_VS_USE;
            ST_VS_USE:  state_next = j_last ? ST_VS_END : ST_VS_RD;
            ST_VS_END:  state_next = ST_VS_SCAN;
            ST_TERM_EMIT: begin
                if (out_free) state_next = ST_TERM_RD;
            end
            ST_TERM_RD:  state_next = ST_TERM_USE;
            ST_TERM_USE: state_next = j_last ? ST_DET_INIT : ST_TERM_RD;
            ST_REPORT: begin
                if (out_free && i_reg == cnt_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        nprocs_next = nprocs_reg;
        nres_next   = nres_reg;
        np_next     = np_reg;
        nr_next     = nr_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        fits_next   = fits_reg;
        have_next   = have_reg;
        tot_next    = tot_reg;
        best_next   = best_reg;
        victim_next = victim_reg;
        fin_next    = fin_reg;
        term_next   = term_reg;
        avail_next  = avail_reg;
        work_next   = work_reg;
        abuf_next   = abuf_reg;
        order_next  = order_reg;
        mv_next     = mv_reg && !m_ready;
        kind_next   = kind_reg;
        val_next    = val_reg;
        last_next   = last_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_NUM_PROCS) nprocs_next = cfg_data;
            else if (cfg_index == CFG_NUM_RESOURCES) nres_next = cfg_data[3:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_opcode == OP_LOAD_AVAIL
                    && 32'(s_resource) < MAX_RESOURCES) begin
                    avail_next[RW'(s_resource)] = AW'(UNIT_BITS'(s_avail_units));
                end
                if (s_fire && s_opcode == OP_RUN) begin
                    term_next = '0;
                    if (nprocs_reg == '0) np_next = CW'(1);
                    else if (32'(nprocs_reg) > MAX_PROCS) np_next = CW'(MAX_PROCS);
                    else np_next = CW'(nprocs_reg);
                    if (nres_reg == '0) nr_next = RCW'(1);
                    else if (32'(nres_reg) > MAX_RESOURCES) nr_next = RCW'(MAX_RESOURCES);
                    else nr_next = RCW'(nres_reg);
                end
            end
            ST_DET_INIT: begin
                fin_next  = '0;
                cnt_next  = '0;
                work_next = avail_reg;
                i_next    = '0;
            end
            ST_SCAN: begin
                if (i_end) begin
                    i_next    = '0;
                    have_next = 1'b0;
                end else if (fin_reg[i_idx]) begin
                    i_next = i_reg + CW'(1);
                end else begin
                    j_next    = '0;
                    fits_next = 1'b1;
                end
            end
            ST_ROW_RD: ;
            ST_ROW_USE: begin
                if (AW'(rd_req) > work_reg[j_reg]) fits_next = 1'b0;
                abuf_next[j_reg] = rd_alloc;
                j_next = j_reg + RW'(1);
            end
            ST_ROW_END: begin
                if (fits_reg) begin
                    for (int k = 0; k < MAX_RESOURCES; k++) begin
                        if (k < nr_reg) work_next[k] = sat_add(work_reg[k], abuf_reg[k]);
                    end
                    fin_next[i_idx] = 1'b1;
                    if (!term_reg[i_idx] && cnt_reg < CW'(MAX_PROCS)) begin
                        order_next[cnt_reg[PW-1:0]] = i_idx;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    i_next = '0;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_VS_SCAN: begin
                if (!i_end) begin
                    if (fin_reg[i_idx]) begin
                        i_next = i_reg + CW'(1);
                    end else begin
                        j_next   = '0;
                        tot_next = '0;
                    end
                end
            end
            ST_VS_RD: ;
            ST_VS_USE: begin
                tot_next = tot_reg + TW'(rd_req) + TW'(rd_alloc);
                j_next   = j_reg + RW'(1);
            end
            ST_VS_END: begin
                if (!have_reg || tot_reg > best_reg) begin
                    best_next   = tot_reg;
                    victim_next = i_idx;
                    have_next   = 1'b1;
                end
                i_next = i_reg + CW'(1);
            end
            ST_TERM_EMIT: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    kind_next = EV_TERMINATED;
                    val_next  = OUTV_W'(victim_reg);
                    last_next = 1'b0;
                    term_next[victim_reg] = 1'b1;
                    j_next    = '0;
                end
            end
            ST_TERM_RD: ;
            ST_TERM_USE: begin
                avail_next[j_reg] = sat_add(avail_reg[j_reg], rd_alloc);
                j_next = j_reg + RW'(1);
            end
            ST_REPORT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    if (i_reg == cnt_reg) begin
                        kind_next = EV_END;
                        val_next  = OUTV_W'(cnt_reg);
                        last_next = 1'b1;
                    end else begin
                        kind_next = EV_COMPLETED;
                        val_next  = OUTV_W'(order_reg[i_idx]);
                        last_next = 1'b0;
                        i_next    = i_reg + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            nprocs_reg <= CDAT_W'(16);
            nres_reg   <= 4'd8;
            fin_reg    <= '0;
            term_reg   <= '0;
            cnt_reg    <= '0;
            mv_reg     <= 1'b0;
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                work_reg[k] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            nprocs_reg <= nprocs_next;
            nres_reg   <= nres_next;
            fin_reg    <= fin_next;
            term_reg   <= term_next;
            cnt_reg    <= cnt_next;
            mv_reg     <= mv_next;
            work_reg   <= work_next;
        end
    end

    always_ff @(posedge aclk) begin
        np_reg     <= np_next;
        nr_reg     <= nr_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        fits_reg   <= fits_next;
        have_reg   <= have_next;
        tot_reg    <= tot_next;
        best_reg   <= best_next;
        victim_reg <= victim_next;
        avail_reg  <= avail_next;
        abuf_reg   <= abuf_next;
        order_reg  <= order_next;
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
    end

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && last_reg) |-> (kind_reg == EV_END))
        else $error("end flag on a non-end item");

    a_victim_unfinished: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TERM_EMIT) |-> (have_reg && !fin_reg[victim_reg]))
        else $error("victim is not an unfinished process");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_DET_INIT) |-> (cnt_reg <= np_reg))
        else $error("completion count beyond process count");

    a_no_emit_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> mv_reg)
        else $error("item dropped while stalled");

endmodule

>>> bench/ddr_checker.sv
`timescale 1ns / 1ps

module ddr_checker
    import ddr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [3:0] s_process,
    input  logic [2:0] s_resource,
    input  logic [7:0] s_request_units,
    input  logic [7:0] s_alloc_units,
    input  logic [7:0] s_avail_units,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_event_kind,
    input  logic [4:0] m_proc_or_count,
    input  logic       m_last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CDAT_W-1:0] cfg_data,
    output int         errors,
    output int         pending,
    output int         results_seen,
    output int         runs_seen
);

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] val;
        logic       last;
    } report_t;

    localparam int AVAIL_MAX = 8191;

    logic [7:0]  req_tab [16][8];
    logic [7:0]  alc_tab [16][8];
    logic [12:0] avail   [8];
    logic [4:0]  procs_reg;
    logic [3:0]  res_reg;
    report_t     reports_due[$];

    assign pending = reports_due.size();

    function automatic logic [12:0] sat_sum(int a, int b);
        return (a + b > AVAIL_MAX) ? 13'(AVAIL_MAX) : 13'(a + b);
    endfunction

    task automatic predict_run();
        int np, nr, best, victim, tot;
        bit have, prog, fits, stuck;
        logic [15:0] fin, term;
        logic [12:0] work[8];
        int order[$];
        np = (procs_reg < 1) ? 1 : (procs_reg > 16) ? 16 : procs_reg;
        nr = (res_reg < 1) ? 1 : (res_reg > 8) ? 8 : res_reg;
        term = '0;
        forever begin
            fin = '0;
            order.delete();
            for (int j = 0; j < 8; j++) work[j] = avail[j];
            prog = 1;
            while (prog) begin
                prog = 0;
                for (int i = 0; i < np && !prog; i++) begin
                    if (!fin[i]) begin
                        fits = 1;
                        for (int j = 0; j < nr; j++)
                            if (req_tab[i][j] > work[j]) fits = 0;
                        if (fits) begin
                            for (int j = 0; j < nr; j++)
                                work[j] = sat_sum(work[j], alc_tab[i][j]);
                            fin[i] = 1;
                            if (!term[i]) order.push_back(i);
                            prog = 1;
                        end
                    end
                end
            end
            stuck = 0;
            for (int i = 0; i < np; i++) if (!fin[i]) stuck = 1;
            if (!stuck) break;
            have = 0;
            best = 0;
            victim = 0;
            for (int i = 0; i < np; i++) begin
                if (!fin[i]) begin
                    tot = 0;
                    for (int j = 0; j < nr; j++) tot += req_tab[i][j] + alc_tab[i][j];
                    if (!have || tot > best) begin
                        best = tot;
                        victim = i;
                        have = 1;
                    end
                end
            end
            reports_due.push_back('{EV_TERMINATED, 5'(victim), 1'b0});
            term[victim] = 1;
            for (int j = 0; j < nr; j++) begin
                avail[j] = sat_sum(avail[j], alc_tab[victim][j]);
                req_tab[victim][j] = '0;
                alc_tab[victim][j] = '0;
            end
        end
        foreach (order[k]) reports_due.push_back('{EV_COMPLETED, 5'(order[k]), 1'b0});
        reports_due.push_back('{EV_END, 5'(order.size()), 1'b1});
    endtask

    always @(posedge aclk) begin
        report_t want;
        if (!aresetn) begin
            procs_reg <= 5'd16;
            res_reg   <= 4'd8;
            errors = 0;
            results_seen = 0;
            runs_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_NUM_PROCS) procs_reg <= cfg_data;
                else if (cfg_index == CFG_NUM_RESOURCES) res_reg <= cfg_data[3:0];
            end
            if (s_valid && s_ready) begin
                case (s_opcode)
                    OP_LOAD_CELL: begin
                        req_tab[s_process][s_resource] = s_request_units;
                        alc_tab[s_process][s_resource] = s_alloc_units;
                    end
                    OP_LOAD_AVAIL: avail[s_resource] = 13'(s_avail_units);
                    OP_RUN: begin
                        runs_seen++;
                        predict_run();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (reports_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item kind=%0d val=%0d last=%0d", $time,
                             m_event_kind, m_proc_or_count, m_last);
                end else begin
                    want = reports_due.pop_front();
                    if (want.kind !== m_event_kind) begin
                        errors++;
                        $display("%0t: event_kind expected %0d actual %0d", $time,
                                 want.kind, m_event_kind);
                    end
                    if (want.val !== m_proc_or_count) begin
                        errors++;
                        $display("%0t: proc_or_count expected %0d actual %0d", $time,
                                 want.val, m_proc_or_count);
                    end
                    if (want.last !== m_last) begin
                        errors++;
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, m_last);
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ddr_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode = '0;
    logic [3:0] s_process = '0;
    logic [2:0] s_resource = '0;
    logic [7:0] s_request_units = '0;
    logic [7:0] s_alloc_units = '0;
    logic [7:0] s_avail_units = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_event_kind;
    logic [4:0] m_proc_or_count;
    logic       m_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CDAT_W-1:0] cfg_data = '0;

    int errors, pending, results_seen, runs_seen;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_req = 0;
    logic hold_off = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;
    int cur_procs = 16;
    int cur_res = 8;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    deadlock_detect_recover_top dut (.*);

    ddr_checker chk (.*);

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(8, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_ready <= !hold_off;
            1: m_ready <= !hold_off && ($urandom_range(0, 1) == 1);
            2: m_ready <= !hold_off && ($urandom_range(0, 3) == 0);
            default: m_ready <= !hold_off && ($urandom_range(0, 7) != 0);
        endcase
    end

    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (600) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic send(logic [1:0] op, logic [3:0] p, logic [2:0] r,
                        logic [7:0] rq, logic [7:0] al, logic [7:0] av);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_process <= p;
        s_resource <= r;
        s_request_units <= rq;
        s_alloc_units <= al;
        s_avail_units <= av;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        if (op != 2'd3) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic drop_valid();
        if (s_valid) s_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic settle();
        drop_valid();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_size(int np, int nr);
        settle();
        write_reg(CFG_NUM_PROCS, 5'(np));
        write_reg(CFG_NUM_RESOURCES, 5'(nr));
        cur_procs = (np < 1) ? 1 : (np > 16) ? 16 : np;
        cur_res = (nr < 1) ? 1 : (nr > 8) ? 8 : nr;
    endtask

    task automatic random_load(int lim);
        if ($urandom_range(0, 5) == 0)
            send(OP_LOAD_AVAIL, 4'($urandom), 3'($urandom_range(0, cur_res - 1)),
                 8'($urandom), 8'($urandom), 8'($urandom_range(0, lim)));
        else if ($urandom_range(0, 9) == 0)
            send(OP_LOAD_CELL, 4'($urandom), 3'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
        else
            send(OP_LOAD_CELL, 4'($urandom_range(0, cur_procs - 1)),
                 3'($urandom_range(0, cur_res - 1)), 8'($urandom_range(0, lim)),
                 8'($urandom_range(0, lim)), 8'($urandom));
    endtask

    initial begin
        int lim;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every cell and available entry before any run
        for (int p = 0; p < 16; p++)
            for (int r = 0; r < 8; r++)
                send(OP_LOAD_CELL, 4'(p), 3'(r), 8'($urandom_range(0, 3)),
                     8'($urandom), 8'($urandom));
        for (int r = 0; r < 8; r++)
            send(OP_LOAD_AVAIL, 4'(r), 3'(r), 8'($urandom), 8'($urandom), 8'd2);

        set_size(31, 15);
        send(OP_RUN, 4'hf, 3'h7, 8'hff, 8'hff, 8'hff);
        send(2'd3, 4'h0, 3'h0, 8'h00, 8'h00, 8'h00);
        set_size(0, 0);
        send(OP_RUN, 4'h0, 3'h0, 8'h00, 8'h00, 8'h00);
        set_size(2, 1);
        send(OP_LOAD_AVAIL, 4'h0, 3'd0, 8'h00, 8'h00, 8'd0);
        send(OP_LOAD_CELL, 4'd0, 3'd0, 8'd9, 8'd1, 8'h00);
        send(OP_LOAD_CELL, 4'd1, 3'd0, 8'd9, 8'd1, 8'h00);
        send(OP_RUN, 4'h0, 3'h0, 8'h00, 8'h00, 8'h00);
        send(OP_LOAD_CELL, 4'd1, 3'd0, 8'd255, 8'd255, 8'h00);
        send(OP_LOAD_AVAIL, 4'h0, 3'd0, 8'h00, 8'h00, 8'd255);
        send(OP_RUN, 4'h0, 3'h0, 8'h00, 8'h00, 8'h00);
        set_size(16, 8);
        send(OP_RUN, 4'h0, 3'h0, 8'h00, 8'h00, 8'h00);

        while (items_sent < 330) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 7) == 0)
                    set_size($urandom_range(0, 31), $urandom_range(0, 15));
                else
                    set_size($urandom_range(1, 6), $urandom_range(1, 4));
            end
            lim = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 6);
            repeat ($urandom_range(3, 16)) begin
                random_load(lim);
                if ($urandom_range(0, 30) == 0)
                    send(2'd3, 4'($urandom), 3'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            end
            if (!hold_req && items_sent > 200) begin
                hold_req = 1;
                burst_left = 40;
                send(OP_RUN, 4'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
                repeat (30) random_load(lim);
            end
            send(OP_RUN, 4'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
        end

        settle();
        repeat (60) @(posedge aclk);
        $display("covered %0d accepted items, %0d runs, %0d result items", items_sent,
                 runs_seen, results_seen);
        if (errors == 0)
            $display("deadlock_detect_recover_top: match");
        else
            $display("deadlock_detect_recover_top: mismatch");
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout with %0d result items outstanding", pending);
        $display("deadlock_detect_recover_top: mismatch");
        $finish;
    end

endmodule
